/* hw/rtl/ppu_dts_pkg.sv */
// ----------------------------------------------------------------------------
// ppu_dts_pkg
// Types and constants shared by the dot timing and scroll counter.
// ----------------------------------------------------------------------------
package ppu_dts_pkg;

   localparam logic [8:0] LAST_DOT          = 9'd340;
   localparam logic [8:0] LAST_LINE         = 9'd261;
   localparam logic [8:0] VBLANK_LINE       = 9'd241;
   localparam logic [8:0] LAST_VISIBLE_LINE = 9'd239;
   localparam logic [8:0] VISIBLE_DOTS      = 9'd256;
   localparam logic [8:0] Y_INC_DOT         = 9'd256;
   localparam logic [8:0] H_COPY_DOT        = 9'd257;
   localparam logic [8:0] V_COPY_FIRST      = 9'd280;
   localparam logic [8:0] V_COPY_LAST       = 9'd304;
   localparam logic [8:0] PREFETCH_DOT_A    = 9'd328;
   localparam logic [8:0] PREFETCH_DOT_B    = 9'd336;
   localparam logic [8:0] FIRST_TILE_DOT    = 9'd8;
   localparam logic [8:0] FLAG_DOT          = 9'd1;

   localparam logic [14:0] H_KEEP_MASK = 15'h7BE0;
   localparam logic [14:0] H_COPY_MASK = 15'h041F;
   localparam logic [14:0] V_KEEP_MASK = 15'h041F;
   localparam logic [14:0] V_COPY_MASK = 15'h7BE0;
   localparam logic [14:0] FINE_Y_ONE  = 15'h1000;

   localparam logic [4:0] COARSE_LAST  = 5'd31;
   localparam logic [4:0] COARSE_Y_ROW = 5'd29;
   localparam logic [2:0] FINE_Y_LAST  = 3'd7;

   typedef struct packed {
      logic [8:0]  dot;
      logic [8:0]  line;
      logic [14:0] v;
      logic        vblank;
   } ppu_state_type;

   typedef struct packed {
      logic [8:0]  dot;
      logic [8:0]  scanline;
      logic [14:0] scroll_addr;
      logic        vblank;
      logic        pixel_visible;
      logic        frame_done;
   } ppu_result_type;

endpackage

/* hw/rtl/ppu_dts_step.sv */
// ----------------------------------------------------------------------------
// ppu_dts_step
// Next-state logic for one dot tick: counters, scroll address, vblank flag, result fields.
// ----------------------------------------------------------------------------
module ppu_dts_step
   import ppu_dts_pkg::*;
(
   input  ppu_state_type  cur,
   input  logic           render_enable,
   input  logic [14:0]    temp_addr,
   output ppu_state_type  nxt,
   output ppu_result_type result
);

   function automatic logic [14:0] coarse_x_inc(input logic [14:0] v);
      logic [14:0] r;
      if (v[4:0] == COARSE_LAST) begin
         r = {v[14:11], ~v[10], v[9:5], 5'd0};
      end else begin
         r = v + 15'd1;
      end
      return r;
   endfunction

   function automatic logic [14:0] y_inc(input logic [14:0] v);
      logic [14:0] r;
      logic [4:0]  y;
      logic        nt;
      if (v[14:12] != FINE_Y_LAST) begin
         r = v + FINE_Y_ONE;
      end else begin
         y  = v[9:5];
         nt = v[11];
         if (y == COARSE_Y_ROW) begin
            y  = 5'd0;
            nt = ~nt;
         end else if (y == COARSE_LAST) begin
            y = 5'd0;
         end else begin
            y = y + 5'd1;
         end
         r = {3'd0, nt, v[10], y, v[4:0]};
      end
      return r;
   endfunction

   logic        render_line;
   logic        x_inc_dot;
   logic [14:0] v_a;
   logic [14:0] v_b;
   logic [14:0] v_c;
   logic        vblank_clr;
   logic        dot_wrap;
   logic        line_wrap;

   always_comb begin
      render_line = (cur.line <= LAST_VISIBLE_LINE) || (cur.line == LAST_LINE);
      x_inc_dot   = ((cur.dot[2:0] == 3'd0) && (cur.dot >= FIRST_TILE_DOT) &&
                     (cur.dot <= Y_INC_DOT)) ||
                    (cur.dot == PREFETCH_DOT_A) || (cur.dot == PREFETCH_DOT_B);

      v_a = cur.v;
      if ((cur.line == LAST_LINE) && (cur.dot >= V_COPY_FIRST) &&
          (cur.dot <= V_COPY_LAST)) begin
         v_a = (cur.v & V_KEEP_MASK) | (temp_addr & V_COPY_MASK);
      end
      v_b = x_inc_dot ? coarse_x_inc(v_a) : v_a;
      if (cur.dot == Y_INC_DOT) begin
         v_c = y_inc(v_b);
      end else if (cur.dot == H_COPY_DOT) begin
         v_c = (v_b & H_KEEP_MASK) | (temp_addr & H_COPY_MASK);
      end else begin
         v_c = v_b;
      end

      nxt.v = (render_enable && render_line) ? v_c : cur.v;

      vblank_clr = (cur.line == LAST_LINE) && (cur.dot == FLAG_DOT);
      if ((cur.line == VBLANK_LINE) && (cur.dot == FLAG_DOT)) begin
         nxt.vblank = 1'b1;
      end else if (vblank_clr) begin
         nxt.vblank = 1'b0;
      end else begin
         nxt.vblank = cur.vblank;
      end

      dot_wrap  = cur.dot >= LAST_DOT;
      line_wrap = dot_wrap && (cur.line >= LAST_LINE);
      nxt.dot   = dot_wrap ? 9'd0 : cur.dot + 9'd1;
      if (line_wrap) begin
         nxt.line = 9'd0;
      end else if (dot_wrap) begin
         nxt.line = cur.line + 9'd1;
      end else begin
         nxt.line = cur.line;
      end

      result.dot           = cur.dot;
      result.scanline      = cur.line;
      result.scroll_addr   = nxt.v;
      result.vblank        = nxt.vblank;
      result.pixel_visible = render_enable && (cur.line <= LAST_VISIBLE_LINE) &&
                             (cur.dot < VISIBLE_DOTS);
      result.frame_done    = line_wrap;
   end

endmodule

/* hw/rtl/ppu_dot_timing_and_scroll_top.sv */
// ----------------------------------------------------------------------------
// ppu_dot_timing_and_scroll_top: dot timing and scroll address counter
// Request register, then the tick logic into the response register.
// Throughput one request per cycle, unless rsp_stall holds a full response register.
// Synchronous reset empties both stages and zeroes dot, line, scroll address, vblank.
// ----------------------------------------------------------------------------
module ppu_dot_timing_and_scroll_top
   import ppu_dts_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_render_enable,
   input  logic [14:0] req_temp_addr,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [8:0]  rsp_dot,
   output logic [8:0]  rsp_scanline,
   output logic [14:0] rsp_scroll_addr,
   output logic        rsp_vblank,
   output logic        rsp_pixel_visible,
   output logic        rsp_frame_done
);

   logic           in_valid_ff;
   logic           in_valid_in;
   logic           in_en_ff;
   logic [14:0]    in_temp_ff;
   logic           rsp_valid_ff;
   logic           rsp_valid_in;
   ppu_result_type rsp_data_ff;
   ppu_state_type  state_ff;
   ppu_state_type  state_in;
   ppu_result_type step_result;
   logic           out_open;
   logic           tick_fire;

   assign out_open  = !rsp_valid_ff || !rsp_stall;
   assign tick_fire = in_valid_ff && out_open;
   assign req_stall = in_valid_ff && !out_open;

   ppu_dts_step u_step (
      .cur           (state_ff),
      .render_enable (in_en_ff),
      .temp_addr     (in_temp_ff),
      .nxt           (state_in),
      .result        (step_result)
   );

   always_comb begin
      in_valid_in  = req_stall ? in_valid_ff : req_valid;
      rsp_valid_in = out_open ? in_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (tick_fire) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         in_en_ff   <= req_render_enable;
         in_temp_ff <= req_temp_addr;
      end
      if (tick_fire) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_dot           = rsp_data_ff.dot;
   assign rsp_scanline      = rsp_data_ff.scanline;
   assign rsp_scroll_addr   = rsp_data_ff.scroll_addr;
   assign rsp_vblank        = rsp_data_ff.vblank;
   assign rsp_pixel_visible = rsp_data_ff.pixel_visible;
   assign rsp_frame_done    = rsp_data_ff.frame_done;

`ifndef SYNTHESIS
   a_frame_done_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> (rsp_dot == LAST_DOT) && (rsp_scanline == LAST_LINE))
      else $error("frame_done away from the last dot of the pre-render line");

   a_visible_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pixel_visible |->
         (rsp_dot < VISIBLE_DOTS) && (rsp_scanline <= LAST_VISIBLE_LINE))
      else $error("pixel_visible outside the visible area");

   a_counter_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff.dot <= LAST_DOT) && (state_ff.line <= LAST_LINE))
      else $error("dot or line counter out of range");

   a_vblank_set: assert property (@(posedge clock) disable iff (reset)
      tick_fire && (state_ff.line == VBLANK_LINE) && (state_ff.dot == FLAG_DOT)
      |=> state_ff.vblank)
      else $error("vblank not set at its start dot");

   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !tick_fire |=> $stable(state_ff))
      else $error("tick state changed without a request");
`endif

endmodule
